FILE: design/hpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpc_pkg
// Shared types and constants of the heatmap peak / centroid block.
// ----------------------------------------------------------------------------
package hpc_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_THRESHOLD = 3'd0;
  localparam logic [2:0] CFG_WIDTH     = 3'd1;
  localparam logic [2:0] CFG_HEIGHT    = 3'd2;
  localparam logic [2:0] CFG_LIMIT     = 3'd3;
  localparam logic [2:0] CFG_CHANNELS  = 3'd4;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam int HEIGHT_CAP = 4096;
  localparam int ROW_BITS   = 12;
  localparam int FRAC_BITS  = 6;
  localparam int QUO_BITS   = 18;   // centroid quotient, covers x and y
  localparam int CX_BITS    = 16;
  localparam int CY_BITS    = 18;
  localparam int CH_BITS    = 6;
  localparam int PK_BITS    = 8;

  localparam logic KIND_PEAK  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_CHECK,
    S_ACC,
    S_DIVGO,
    S_DIV,
    S_PEAK,
    S_COUNT
  } hpc_state_e;

endpackage

FILE: design/heatmap_peak_centroid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heatmap_peak_centroid
// Raster heatmap peak finder with 3x3 suppression and 5x5 weighted centroid.
// ----------------------------------------------------------------------------
// Scores stream in raster order, one frame per channel. Each pixel passes
// through transfer with the line memory read, window update with write-back,
// then the peak test. A detected peak adds the serial 5x5 weighted sum, the
// bit-serial divider including its start state, and the record output; the
// end of a frame adds the count record. The input is stalled meanwhile. The
// single-port line memory read-modify-write, the shared multiply-accumulate
// and the serial divider set this pacing.
// Line memory contents are not cleared; rows above the frame top are masked.
// ----------------------------------------------------------------------------
module heatmap_peak_centroid
  import hpc_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int SCORE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [15:0]              pixel_score_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     record_kind_o,
  output logic [CH_BITS-1:0]       channel_index_o,
  output logic [CX_BITS-1:0]       centroid_x_o,
  output logic [CY_BITS-1:0]       centroid_y_o,
  output logic [15:0]              peak_score_o,
  output logic [PK_BITS-1:0]       peak_total_o,
  output logic                     last_result_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int SB   = SCORE_BITS;
  localparam int CPW  = $clog2(MAX_WIDTH);
  localparam int CW   = (CPW > ROW_BITS) ? CPW : ROW_BITS;
  localparam int CMPW = (SB > 16) ? SB : 16;
  localparam int SXW  = CW + SB + 5;
  localparam int SWW  = SB + 5;
  localparam int NW   = SXW + FRAC_BITS + 1;
  localparam int DW   = SWW + 1;

  hpc_state_e state_q, state_d;

  // configuration
  logic [15:0] thr_q;
  logic [10:0] fw_q;
  logic [12:0] fh_q;
  logic [7:0]  lim_q;
  logic [6:0]  cc_q;

  // frame position
  logic [CPW-1:0]      col_q;
  logic [ROW_BITS-1:0] row_q;
  logic [PK_BITS-1:0]  pk_q;
  logic [CH_BITS-1:0]  ch_q;

  // current pixel
  logic [SB-1:0]       pix_q;
  logic [CPW-1:0]      c_q;
  logic [ROW_BITS-1:0] r_q;
  logic                lc_q, lr_q;

  logic [SB-1:0] win_q [5][5];

  // centroid accumulation
  logic           ci_q, cj_q;
  logic [2:0]     a_q, b_q;
  logic [SXW-1:0] sx_q, sy_q;
  logic [SWW-1:0] sw_q;

  // output register
  logic                out_valid_q;
  logic                kind_q, last_q;
  logic [CH_BITS-1:0]  och_q;
  logic [CX_BITS-1:0]  cx_q;
  logic [CY_BITS-1:0]  cy_q;
  logic [15:0]         osc_q;
  logic [PK_BITS-1:0]  tot_q;

  // fsm outputs
  logic in_take, mem_re, mem_we, div_start, load_peak, load_count;
  logic [CPW-1:0] mem_addr;

  logic [4*SB-1:0] mem_rdata, mem_wdata;
  logic            div_busy_x, div_busy_y;
  logic [QUO_BITS-1:0] quo_x, quo_y;
  logic [NW-1:0]   num_x, num_y;
  logic [DW-1:0]   den;

  // geometry
  int             fw_i, fh_i, w_i, h_i, cc_i;
  logic [CPW-1:0] c_now;
  logic [ROW_BITS-1:0] r_now;
  logic           lc_now, lr_now;
  logic           out_free;

  always_comb begin
    fw_i = int'(fw_q);
    fh_i = int'(fh_q);
    cc_i = int'(cc_q);
    w_i  = (fw_i < 3) ? 3 : ((fw_i > MAX_WIDTH) ? MAX_WIDTH : fw_i);
    h_i  = (fh_i < 3) ? 3 : ((fh_i > HEIGHT_CAP) ? HEIGHT_CAP : fh_i);
    cc_i = (cc_i < 1) ? 1 : ((cc_i > 64) ? 64 : cc_i);
    c_now  = (int'(col_q) >= w_i) ? '0 : col_q;
    r_now  = (int'(row_q) >= h_i) ? '0 : row_q;
    lc_now = int'(c_now) == w_i - 1;
    lr_now = int'(r_now) == h_i - 1;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // ---------------- peak test on the four candidate centres ----------------
  logic [3:0] en, hit;
  logic       any_hit, sel_ci, sel_cj;

  assign en = {lc_q & lr_q, lc_q, lr_q, 1'b1};

  for (genvar k = 0; k < 4; k++) begin : g_cand
    localparam logic [2:0] CI = 3'(2 + (k % 2));
    localparam logic [2:0] CJ = 3'(2 + (k / 2));
    always_comb begin
      int px, py;
      logic nb_ok;
      px    = int'(c_q) - 4 + int'(CJ);
      py    = int'(r_q) - 4 + int'(CI);
      nb_ok = 1'b1;
      for (int di = -1; di <= 1; di++) begin
        for (int dj = -1; dj <= 1; dj++) begin
          if ((di != 0 || dj != 0) &&
              !(win_q[CI][CJ] > win_q[3'(int'(CI) + di)][3'(int'(CJ) + dj)])) begin
            nb_ok = 1'b0;
          end
        end
      end
      hit[k] = en[k] && nb_ok && (px >= 1) && (px <= w_i - 2) && (py >= 1) &&
               (py <= h_i - 2) && (CMPW'(win_q[CI][CJ]) >= CMPW'(thr_q));
    end
  end

  always_comb begin
    any_hit = (hit != 4'b0) && (pk_q < lim_q);
    sel_ci  = !hit[0] && (hit[1] || !hit[2]);
    sel_cj  = !hit[0] && !hit[1];
  end

  // ---------------- centroid step ----------------
  logic [2:0]       iw, jw;
  int               xc_i, yc_i;
  logic             take;
  logic [SB-1:0]    s_sel;
  logic [CW+SB-1:0] prx, pry;

  always_comb begin
    iw    = a_q + 3'(ci_q);
    jw    = b_q + 3'(cj_q);
    xc_i  = int'(c_q) - 4 + int'(jw);
    yc_i  = int'(r_q) - 4 + int'(iw);
    s_sel = win_q[(iw < 3'd5) ? iw : 3'd0][(jw < 3'd5) ? jw : 3'd0];
    take  = (iw < 3'd5) && (jw < 3'd5) && (xc_i >= 0) && (yc_i >= 0) &&
            (CMPW'(s_sel) > CMPW'(thr_q));
    prx   = (CW+SB)'(CW'(xc_i)) * (CW+SB)'(s_sel);
    pry   = (CW+SB)'(CW'(yc_i)) * (CW+SB)'(s_sel);
  end

  // rounded mean: (s*128 + w) / (2w)
  always_comb begin
    num_x = (NW'(sx_q) << (FRAC_BITS + 1)) + NW'(sw_q);
    num_y = (NW'(sy_q) << (FRAC_BITS + 1)) + NW'(sw_q);
    den   = {sw_q, 1'b0};
  end

  hpc_div #(.NW(NW), .DW(DW), .QW(QUO_BITS)) u_div_x (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_x), .den_i(den),
    .busy_o(div_busy_x), .quo_o(quo_x)
  );

  hpc_div #(.NW(NW), .DW(DW), .QW(QUO_BITS)) u_div_y (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_y), .den_i(den),
    .busy_o(div_busy_y), .quo_o(quo_y)
  );

  hpc_line_mem #(.DEPTH(MAX_WIDTH), .WIDTH(4 * SB)) u_line_mem (
    .clk_i, .re_i(mem_re), .we_i(mem_we), .addr_i(mem_addr),
    .wdata_i(mem_wdata), .rdata_o(mem_rdata)
  );

  // newest row in the low slot
  assign mem_wdata = {mem_rdata[3*SB-1:0], pix_q};

  // ---------------- control ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_LOAD;
      S_LOAD:  state_d = S_CHECK;
      S_CHECK: begin
        if (any_hit) state_d = S_ACC;
        else if (lc_q && lr_q) state_d = S_COUNT;
        else state_d = S_IDLE;
      end
      S_ACC:   if (a_q == 3'd4 && b_q == 3'd4) state_d = S_DIVGO;
      S_DIVGO: state_d = S_DIV;
      S_DIV:   if (!div_busy_x && !div_busy_y) state_d = S_PEAK;
      S_PEAK: begin
        if (out_free) state_d = (lc_q && lr_q) ? S_COUNT : S_IDLE;
      end
      S_COUNT: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    in_take    = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = c_q;
    div_start  = 1'b0;
    load_peak  = 1'b0;
    load_count = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        in_take    = in_valid_i;
        mem_re     = in_valid_i;
        mem_addr   = c_now;
      end
      S_LOAD:  mem_we = 1'b1;
      S_DIVGO: div_start = 1'b1;
      S_PEAK:  load_peak = out_free;
      S_COUNT: load_count = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      thr_q   <= '0;
      fw_q    <= 11'd64;
      fh_q    <= 13'd64;
      lim_q   <= 8'd64;
      cc_q    <= 7'd1;
      col_q   <= '0;
      row_q   <= '0;
      pk_q    <= '0;
      ch_q    <= '0;
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 5; j++) begin
          win_q[i][j] <= '0;
        end
      end
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_THRESHOLD: thr_q <= cfg_data_i;
          CFG_WIDTH: begin
            fw_q  <= cfg_data_i[10:0];
            col_q <= '0;
            row_q <= '0;
            pk_q  <= '0;
          end
          CFG_HEIGHT: begin
            fh_q  <= cfg_data_i[12:0];
            col_q <= '0;
            row_q <= '0;
            pk_q  <= '0;
          end
          CFG_LIMIT:    lim_q <= cfg_data_i[7:0];
          CFG_CHANNELS: cc_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end

      if (state_q == S_LOAD) begin
        for (int i = 0; i < 5; i++) begin
          for (int j = 0; j < 4; j++) begin
            win_q[i][j] <= win_q[i][j+1];
          end
        end
        for (int i = 0; i < 4; i++) begin
          win_q[i][4] <= mem_rdata[(3-i)*SB +: SB];
        end
        win_q[4][4] <= pix_q;
        if (lc_q) begin
          col_q <= '0;
          row_q <= lr_q ? '0 : r_q + 1'b1;
        end else begin
          col_q <= c_q + 1'b1;
        end
      end

      if (load_peak) begin
        pk_q <= pk_q + 1'b1;
      end else if (load_count) begin
        pk_q <= '0;
        ch_q <= (int'(ch_q) + 1 >= cc_i) ? '0 : ch_q + 1'b1;
      end

      if (load_peak || load_count) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pix_q <= SB'(pixel_score_i);
      c_q   <= c_now;
      r_q   <= r_now;
      lc_q  <= lc_now;
      lr_q  <= lr_now;
    end

    if (state_q == S_CHECK) begin
      ci_q <= sel_ci;
      cj_q <= sel_cj;
      a_q  <= '0;
      b_q  <= '0;
      sx_q <= '0;
      sy_q <= '0;
      sw_q <= '0;
    end else if (state_q == S_ACC) begin
      if (take) begin
        sx_q <= sx_q + SXW'(prx);
        sy_q <= sy_q + SXW'(pry);
        sw_q <= sw_q + SWW'(s_sel);
      end
      if (b_q == 3'd4) begin
        b_q <= '0;
        a_q <= a_q + 1'b1;
      end else begin
        b_q <= b_q + 1'b1;
      end
    end

    if (load_peak) begin
      kind_q <= KIND_PEAK;
      och_q  <= ch_q;
      osc_q  <= 16'(win_q[3'd2 + 3'(ci_q)][3'd2 + 3'(cj_q)]);
      tot_q  <= '0;
      last_q <= !(lc_q && lr_q);
      if (sw_q == '0) begin
        // no weight: report the centre itself
        cx_q <= CX_BITS'({CW'(int'(c_q) - 2 + int'(cj_q)), {FRAC_BITS{1'b0}}});
        cy_q <= CY_BITS'({CW'(int'(r_q) - 2 + int'(ci_q)), {FRAC_BITS{1'b0}}});
      end else begin
        cx_q <= CX_BITS'(quo_x);
        cy_q <= CY_BITS'(quo_y);
      end
    end else if (load_count) begin
      kind_q <= KIND_COUNT;
      och_q  <= ch_q;
      osc_q  <= '0;
      tot_q  <= pk_q;
      last_q <= 1'b1;
      cx_q   <= '0;
      cy_q   <= '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign record_kind_o   = kind_q;
  assign channel_index_o = och_q;
  assign centroid_x_o    = cx_q;
  assign centroid_y_o    = cy_q;
  assign peak_score_o    = osc_q;
  assign peak_total_o    = tot_q;
  assign last_result_o   = last_q;

endmodule

FILE: design/hpc_line_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpc_line_mem
// Single-port line memory, one word per column holding four prior rows.
// ----------------------------------------------------------------------------
module hpc_line_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/hpc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpc_div
// Restoring divider, one quotient bit per cycle. Caller guarantees the
// quotient fits in QW bits.
// ----------------------------------------------------------------------------
module hpc_div #(
  parameter int NW = 40,
  parameter int DW = 22,
  parameter int QW = 18
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic [QW-1:0] quo_o
);

  localparam int CNTW = $clog2(QW + 1);

  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   den_q;
  logic [QW-1:0]   sh_q, quo_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q;
  logic [NW-1:0]   hi;
  logic [DW:0]     trial;
  logic            ge;

  always_comb begin
    hi    = num_i >> QW;
    trial = {rem_q, sh_q[QW-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNTW'(QW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= hi[DW-1:0];
      sh_q  <= num_i[QW-1:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_q << 1;
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule
